FILE: design/iee_pkg.sv
// shared types and constants for the infix expression evaluator
// used by iee_front, iee_back and the top level
package iee_pkg;
   localparam int VALUE_DEPTH_DEF = 16;
   localparam int OPER_DEPTH_DEF  = 16;
   localparam int FRAC_BITS_DEF   = 16;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
      OP_OPEN = 3'd4, OP_CLOSE = 3'd5, OP_END = 3'd6, OP_BAD = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_READY = 3'd1, ST_SYNTAX = 3'd2, ST_OVERFLOW = 3'd3,
      ST_DIVZERO = 3'd4
   } status_type;

   // classified token handed from front to back
   typedef struct packed {
      logic              is_oper;
      logic signed [31:0] operand;
      op_type            op;
   } token_type;
endpackage

FILE: design/iee_front.sv
// front part: takes tokens and keeps them in a short queue
// depends on iee_pkg
module iee_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [39:0]        req_tdata,
   input  logic               req_tuser,
   input  logic               tok_pop,
   output logic               tok_valid,
   output iee_pkg::token_type tok_data
);
   import iee_pkg::*;

   token_type  queue_ff [2];
   logic       wr_ff, rd_ff, wr_in, rd_in;
   logic [1:0] fill_ff, fill_in;
   token_type  tok_new;
   logic       push;

   always_comb begin
      tok_new.is_oper = req_tuser;
      tok_new.operand = req_tdata[31:0];
      tok_new.op      = op_type'(req_tdata[34:32]);
   end

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign tok_valid  = (fill_ff != 2'd0);
   assign tok_data   = queue_ff[rd_ff];

   always_comb begin
      wr_in   = wr_ff ^ push;
      rd_in   = rd_ff ^ tok_pop;
      fill_in = fill_ff + {1'b0, push} - {1'b0, tok_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (push) queue_ff[wr_ff] <= tok_new;
   end

   assert property (@(posedge clock) disable iff (reset) tok_pop |-> tok_valid)
      else $error("pop from empty token queue");
   assert property (@(posedge clock) disable iff (reset) fill_ff != 2'd3)
      else $error("token queue fill out of range");
   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd2) |-> !req_tready)
      else $error("full queue took a token");
endmodule

FILE: design/iee_div.sv
// restoring divider, one quotient bit per cycle, for the back part
// standalone, depends on nothing
module iee_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] dividend,
   input  logic signed [31:0] divisor,
   output logic               done,
   output logic signed [31:0] quotient
);
   localparam int NUM_W = 32 + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [32:0]      rem_ff, rem_in;
   logic [31:0]      den_ff;
   logic             neg_ff, busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [32:0]      trial;
   logic [NUM_W-1:0] mag_a;
   logic [31:0]      mag_b;
   logic [NUM_W:0]   qs;

   always_comb begin
      mag_a = {{FRAC_BITS{dividend[31]}}, dividend} << FRAC_BITS;
      if (dividend[31]) mag_a = -mag_a;
      mag_b = divisor[31] ? -divisor : divisor;
      trial = {rem_ff[31:0], num_ff[NUM_W-1]} - {1'b0, den_ff};
      rem_in = trial[32] ? {rem_ff[31:0], num_ff[NUM_W-1]} : trial;
      num_in = {num_ff[NUM_W-2:0], ~trial[32]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
      if (start) begin
         num_ff <= mag_a;
         rem_ff <= '0;
         den_ff <= mag_b;
         neg_ff <= dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   // signed quotient with saturation
   always_comb begin
      qs = neg_ff ? -{1'b0, num_ff} : {1'b0, num_ff};
      if (!neg_ff && num_ff > NUM_W'(32'h7fffffff)) quotient = 32'sh7fffffff;
      else if (neg_ff && num_ff > NUM_W'(33'h80000000)) quotient = 32'sh80000000;
      else quotient = qs[31:0];
   end
endmodule

FILE: design/iee_back.sv
// back part: runs the two stacks and the reductions for each token
// depends on iee_pkg and iee_div
module iee_back #(
   parameter int VALUE_DEPTH = 16,
   parameter int OPER_DEPTH  = 16,
   parameter int FRAC_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               tok_valid,
   input  iee_pkg::token_type tok_data,
   output logic               tok_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [39:0]        rsp_tdata
);
   import iee_pkg::*;

   localparam int VA_W = $clog2(VALUE_DEPTH);
   localparam int VC_W = $clog2(VALUE_DEPTH + 1);
   localparam int OA_W = $clog2(OPER_DEPTH);
   localparam int OC_W = $clog2(OPER_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DECIDE, S_MUL, S_DIV, S_FINISH, S_OUT
   } state_type;

   typedef enum logic [1:0] {K_NONE, K_VALUE, K_OPER} kind_type;

   state_type   state_ff;
   kind_type    kind_ff;
   logic signed [31:0] vstack_ff [VALUE_DEPTH];
   op_type      ostack_ff [OPER_DEPTH];
   logic [VC_W-1:0] vcnt_ff;
   logic [OC_W-1:0] ocnt_ff;
   token_type   tok_ff;
   status_type  st_ff;
   logic signed [31:0] top_ff;
   logic signed [31:0] va, vb, vtop;
   op_type      otop;
   logic signed [63:0] prod_ff;
   logic        div_start, div_done;
   logic signed [31:0] quo;
   logic signed [32:0] sum;
   logic signed [63:0] shr;
   logic        want_reduce, can_reduce, reduce_div;

   assign vb   = vstack_ff[VA_W'(vcnt_ff - 1'b1)];
   assign va   = vstack_ff[VA_W'(vcnt_ff - 2'd2)];
   assign vtop = vb;
   assign otop = ostack_ff[OA_W'(ocnt_ff - 1'b1)];
   assign tok_pop = (state_ff == S_IDLE) && tok_valid;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {5'd0, top_ff, st_ff};
   assign div_start  = (state_ff == S_DECIDE) && reduce_div;

   iee_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(va),
      .divisor(vb), .done(div_done), .quotient(quo));

   function automatic logic prec2(op_type o);
      return (o == OP_MUL) || (o == OP_DIV);
   endfunction

   // decision for one step of the current token
   always_comb begin
      want_reduce = 1'b0;
      case (tok_ff.op)
         OP_ADD, OP_SUB, OP_MUL, OP_DIV:
            want_reduce = ocnt_ff != 0 && otop <= OP_DIV &&
                          (prec2(otop) || !prec2(tok_ff.op));
         OP_CLOSE: want_reduce = ocnt_ff != 0 && otop != OP_OPEN;
         OP_END:   want_reduce = ocnt_ff != 0 && otop != OP_OPEN;
         default:  want_reduce = 1'b0;
      endcase
      can_reduce = vcnt_ff >= VC_W'(2) && otop <= OP_DIV;
      // only a token that follows a value gets as far as a reduction
      reduce_div = tok_ff.is_oper && kind_ff == K_VALUE && want_reduce && can_reduce
                   && otop == OP_DIV && vb != 0;
      sum = (otop == OP_ADD) ? 33'(va) + 33'(vb) : 33'(va) - 33'(vb);
      shr = prod_ff >>> FRAC_BITS;
   end

   function automatic logic signed [31:0] sat33(logic signed [32:0] x);
      if (x > 33'sh07fffffff) return 32'sh7fffffff;
      if (x < -33'sh080000000) return 32'sh80000000;
      return x[31:0];
   endfunction

   function automatic logic signed [31:0] sat64(logic signed [63:0] x);
      if (x > 64'sh7fffffff) return 32'sh7fffffff;
      if (x < -64'sh80000000) return 32'sh80000000;
      return x[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= K_NONE;
         vcnt_ff  <= '0;
         ocnt_ff  <= '0;
      end else begin
         case (state_ff)
            S_IDLE: if (tok_valid) begin
               tok_ff   <= tok_data;
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               state_ff <= S_OUT;
               top_ff   <= '0;
               st_ff    <= ST_OK;
               if (!tok_ff.is_oper) begin
                  if (kind_ff == K_VALUE) st_ff <= ST_SYNTAX;
                  else if (vcnt_ff >= VC_W'(VALUE_DEPTH)) st_ff <= ST_OVERFLOW;
                  else begin
                     vstack_ff[VA_W'(vcnt_ff)] <= tok_ff.operand;
                     vcnt_ff <= vcnt_ff + 1'b1;
                     kind_ff <= K_VALUE;
                  end
               end else if (tok_ff.op == OP_OPEN) begin
                  if (kind_ff == K_VALUE) st_ff <= ST_SYNTAX;
                  else if (ocnt_ff >= OC_W'(OPER_DEPTH)) st_ff <= ST_OVERFLOW;
                  else begin
                     ostack_ff[OA_W'(ocnt_ff)] <= OP_OPEN;
                     ocnt_ff <= ocnt_ff + 1'b1;
                     kind_ff <= K_OPER;
                  end
               end else if (tok_ff.op == OP_BAD || kind_ff != K_VALUE) begin
                  st_ff <= ST_SYNTAX;
               end else if (want_reduce) begin
                  if (!can_reduce) st_ff <= ST_SYNTAX;
                  else if (otop == OP_DIV && vb == 0) st_ff <= ST_DIVZERO;
                  else if (otop == OP_MUL) begin
                     prod_ff  <= 64'(va) * 64'(vb);
                     state_ff <= S_MUL;
                  end else if (otop == OP_DIV) state_ff <= S_DIV;
                  else begin
                     vstack_ff[VA_W'(vcnt_ff - 2'd2)] <= sat33(sum);
                     vcnt_ff  <= vcnt_ff - 1'b1;
                     ocnt_ff  <= ocnt_ff - 1'b1;
                     state_ff <= S_DECIDE;
                  end
               end else state_ff <= S_FINISH;
            end
            S_MUL: begin
               vstack_ff[VA_W'(vcnt_ff - 2'd2)] <= sat64(shr);
               vcnt_ff  <= vcnt_ff - 1'b1;
               ocnt_ff  <= ocnt_ff - 1'b1;
               state_ff <= S_DECIDE;
            end
            S_DIV: if (div_done) begin
               vstack_ff[VA_W'(vcnt_ff - 2'd2)] <= quo;
               vcnt_ff  <= vcnt_ff - 1'b1;
               ocnt_ff  <= ocnt_ff - 1'b1;
               state_ff <= S_DECIDE;
            end
            S_FINISH: begin
               state_ff <= S_OUT;
               st_ff    <= ST_OK;
               top_ff   <= '0;
               case (tok_ff.op)
                  OP_CLOSE: begin
                     if (ocnt_ff == 0 || vcnt_ff == 0) st_ff <= ST_SYNTAX;
                     else begin
                        ocnt_ff <= ocnt_ff - 1'b1;
                        st_ff   <= ST_READY;
                        top_ff  <= vtop;
                        kind_ff <= K_VALUE;
                     end
                  end
                  OP_END: begin
                     if (ocnt_ff != 0 || vcnt_ff != VC_W'(1)) st_ff <= ST_SYNTAX;
                     else begin
                        st_ff   <= ST_READY;
                        top_ff  <= vtop;
                        vcnt_ff <= '0;
                        kind_ff <= K_NONE;
                     end
                  end
                  default: begin
                     if (ocnt_ff >= OC_W'(OPER_DEPTH)) st_ff <= ST_OVERFLOW;
                     else begin
                        ostack_ff[OA_W'(ocnt_ff)] <= tok_ff.op;
                        ocnt_ff <= ocnt_ff + 1'b1;
                        kind_ff <= K_OPER;
                     end
                  end
               endcase
            end
            S_OUT: begin
               if (st_ff >= ST_SYNTAX) begin
                  vcnt_ff <= '0;
                  ocnt_ff <= '0;
                  kind_ff <= K_NONE;
               end
               if (rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) vcnt_ff <= VC_W'(VALUE_DEPTH))
      else $error("value count beyond depth");
   assert property (@(posedge clock) disable iff (reset) ocnt_ff <= OC_W'(OPER_DEPTH))
      else $error("operator count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && st_ff != ST_READY) |-> top_ff == 0)
      else $error("value shown without ready status");
   assert property (@(posedge clock) disable iff (reset)
      div_start |=> state_ff == S_DIV)
      else $error("divide started outside divide step");
endmodule

FILE: design/infix_expression_evaluator.sv
// channel  | dir | tdata fields (low bit up)              | tuser
// req      | in  | operand[31:0], op_code[34:32]          | action
// rsp      | out | status[2:0], top_value[34:3]           | none
// an item passes through the front queue; the back part then decides on it, doing add/sub
// reductions in the decide step, a multiply in an extra step and a divide by waiting on the
// serial divider, which sets the worst case
// reset is synchronous and active high; stacks read as empty after reset
// the front queue holds two tokens so input can still be taken while a result waits
module infix_expression_evaluator #(
   parameter int VALUE_DEPTH = iee_pkg::VALUE_DEPTH_DEF,
   parameter int OPER_DEPTH  = iee_pkg::OPER_DEPTH_DEF,
   parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // operand, op_code
   input  logic        req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // status, top_value
);
   import iee_pkg::*;

   token_type tok_data;
   logic      tok_valid, tok_pop;

   iee_front u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .req_tdata(req_tdata), .req_tuser(req_tuser),
      .tok_pop(tok_pop), .tok_valid(tok_valid), .tok_data(tok_data));

   iee_back #(.VALUE_DEPTH(VALUE_DEPTH), .OPER_DEPTH(OPER_DEPTH),
              .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .tok_valid(tok_valid),
      .tok_data(tok_data), .tok_pop(tok_pop), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for infix_expression_evaluator
// streams token items, predicts status and top value, depends on iee_pkg
`timescale 1ns / 1ps
module tb_top;
   import iee_pkg::*;

   localparam int VDEPTH = 16;
   localparam int ODEPTH = 16;
   localparam int FRAC = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1550;
   localparam int QUIET_TAIL = 200;

   typedef enum logic [1:0] {KIND_NONE = 2'd0, KIND_VALUE = 2'd1, KIND_OPER = 2'd2} kind_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] top_value;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   infix_expression_evaluator u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // evaluator model state
   logic signed [31:0] vals [VDEPTH];
   int unsigned        nvals;
   op_type             opers [ODEPTH];
   int unsigned        nopers;
   kind_type           last_kind;

   // pending item: action in bit 40, tdata below
   logic [40:0] token_queue [$];
   answer_type  answer_queue [$];
   int          mismatches = 0;
   bit          quiet = 0;
   bit          hold_for_drain = 0;
   bit          stim_done = 0;
   bit          timed_out = 0;

   function automatic logic signed [31:0] sat32(logic signed [63:0] x);
      if (x > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (x < -64'sh80000000) return 32'sh80000000;
      return x[31:0];
   endfunction

   function automatic int prec(op_type op);
      return (op == OP_MUL || op == OP_DIV) ? 2 : 1;
   endfunction

   function automatic void clear_stacks();
      nvals = 0;
      nopers = 0;
      last_kind = KIND_NONE;
   endfunction

   function automatic status_type reduce_top();
      op_type op;
      logic signed [63:0] a, b, r, p;
      if (nopers == 0 || nvals < 2) return ST_SYNTAX;
      op = opers[nopers-1];
      if (op > OP_DIV) return ST_SYNTAX;
      b = vals[nvals-1];
      a = vals[nvals-2];
      case (op)
         OP_ADD: r = a + b;
         OP_SUB: r = a - b;
         OP_MUL: begin
            p = a * b;
            r = p >>> FRAC; // arithmetic shift floors
         end
         default: begin
            if (b == 0) return ST_DIVZERO;
            r = (a <<< FRAC) / b;
         end
      endcase
      nopers--;
      nvals--;
      vals[nvals-1] = sat32(r);
      return ST_OK;
   endfunction

   function automatic answer_type evaluate_token(logic [40:0] tok);
      status_type st = ST_OK;
      logic [31:0] top = '0;
      op_type op = op_type'(tok[34:32]);
      answer_type ans;
      if (!tok[40]) begin
         if (last_kind == KIND_VALUE) st = ST_SYNTAX;
         else if (nvals >= VDEPTH) st = ST_OVERFLOW;
         else begin
            vals[nvals++] = tok[31:0];
            last_kind = KIND_VALUE;
         end
      end else if (op <= OP_DIV) begin
         if (last_kind != KIND_VALUE) st = ST_SYNTAX;
         while (st == ST_OK && nopers > 0 && opers[nopers-1] <= OP_DIV
                && prec(opers[nopers-1]) >= prec(op))
            st = reduce_top();
         if (st == ST_OK) begin
            if (nopers >= ODEPTH) st = ST_OVERFLOW;
            else begin
               opers[nopers++] = op;
               last_kind = KIND_OPER;
            end
         end
      end else if (op == OP_OPEN) begin
         if (last_kind == KIND_VALUE) st = ST_SYNTAX;
         else if (nopers >= ODEPTH) st = ST_OVERFLOW;
         else begin
            opers[nopers++] = op;
            last_kind = KIND_OPER;
         end
      end else if (op == OP_CLOSE) begin
         if (last_kind != KIND_VALUE) st = ST_SYNTAX;
         while (st == ST_OK) begin
            if (nopers == 0) begin
               st = ST_SYNTAX;
               break;
            end
            if (opers[nopers-1] == OP_OPEN) begin
               nopers--;
               break;
            end
            st = reduce_top();
         end
         if (st == ST_OK) begin
            if (nvals == 0) st = ST_SYNTAX;
            else begin
               st = ST_READY;
               top = vals[nvals-1];
               last_kind = KIND_VALUE;
            end
         end
      end else if (op == OP_END) begin
         if (last_kind != KIND_VALUE) st = ST_SYNTAX;
         while (st == ST_OK && nopers > 0) begin
            if (opers[nopers-1] == OP_OPEN) st = ST_SYNTAX;
            else st = reduce_top();
         end
         if (st == ST_OK) begin
            if (nvals != 1) st = ST_SYNTAX;
            else begin
               st = ST_READY;
               top = vals[0];
               clear_stacks();
            end
         end
      end else begin
         st = ST_SYNTAX;
      end
      if (st >= ST_SYNTAX) begin
         clear_stacks();
         top = '0;
      end
      ans.status = st;
      ans.top_value = top;
      return ans;
   endfunction

   function automatic logic [40:0] value_token(logic [31:0] v);
      return {1'b0, 5'b0, 3'b0, v};
   endfunction

   function automatic logic [40:0] oper_token(logic [2:0] op);
      return {1'b1, 5'b0, op, $urandom()}; // operand bits are don't-care noise
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h80000000 | $urandom_range(0, 3);
         2: return 32'h7FFFFFFC | $urandom_range(0, 3);
         3: return 32'h0;
         4: return {12'b0, 20'($urandom_range(0, 20'hFFFFF))};
         default: return -$signed({12'b0, 20'($urandom_range(0, 20'hFFFFF))});
      endcase
   endfunction

   // well-formed expression, optionally spoiled, ending with the end mark
   task automatic push_expression(int spoil);
      int n = $urandom_range(1, 6);
      int depth = 0;
      for (int i = 0; i < n; i++) begin
         while (depth < 3 && $urandom_range(0, 3) == 0) begin
            token_queue.push_back(oper_token(OP_OPEN));
            depth++;
         end
         token_queue.push_back(value_token($urandom_range(0, 9) == 0 ? 32'h0 : rand_value()));
         while (depth > 0 && $urandom_range(0, 2) == 0) begin
            token_queue.push_back(oper_token(OP_CLOSE));
            depth--;
         end
         if (i != n - 1)
            token_queue.push_back(oper_token(3'($urandom_range(OP_ADD, OP_DIV))));
      end
      while (depth > 0) begin
         token_queue.push_back(oper_token(OP_CLOSE));
         depth--;
      end
      if (spoil) begin
         if ($urandom_range(0, 1)) token_queue.push_back(value_token(rand_value()));
         else token_queue.push_back(oper_token(3'($urandom_range(0, 7))));
      end
      token_queue.push_back(oper_token(OP_END));
   endtask

   // driver
   int req_idle = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            answer_queue.push_back(evaluate_token({req_tuser, req_tdata}));
            void'(token_queue.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            // hold item
         end else if (req_idle > 0) begin
            req_idle <= req_idle - 1;
            req_tvalid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 19) == 0) begin
            req_idle <= $urandom_range(0, 15);
            req_tvalid <= 1'b0;
         end else if (token_queue.size() != 0
                      && !(hold_for_drain && (answer_queue.size() != 0 || req_tvalid))) begin
            req_tvalid <= 1'b1;
            req_tuser <= token_queue[0][40];
            req_tdata <= token_queue[0][39:0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   int rsp_idle = 0;
   answer_type got, want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[2:0];
            got.top_value = rsp_tdata[34:3];
            if (answer_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result item %h", rsp_tdata);
            end else begin
               want = answer_queue.pop_front();
               if (got.status !== want.status || got.top_value !== want.top_value
                   || rsp_tdata[39:35] !== 5'b0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: status exp %0d got %0d, top_value exp %h got %h",
                              want.status, got.status, want.top_value, got.top_value);
               end
            end
         end
         if (rsp_idle > 0) begin
            rsp_idle <= rsp_idle - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 19) == 0) begin
            rsp_idle <= $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on accepted items
   int stall_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset ||
          (stim_done && token_queue.size() == 0 && answer_queue.size() == 0))
         stall_cycles <= 0;
      else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      int count;
      int before_n;
      clear_stacks();
      // directed part
      token_queue.push_back(value_token(32'h7FFFFFFF));
      token_queue.push_back(oper_token(OP_ADD));
      token_queue.push_back(value_token(32'h7FFFFFFF));
      token_queue.push_back(oper_token(OP_END));          // saturating add
      token_queue.push_back(value_token(32'h80000000));
      token_queue.push_back(oper_token(OP_MUL));
      token_queue.push_back(value_token(32'hFFFFFFFF));
      token_queue.push_back(oper_token(OP_SUB));
      token_queue.push_back(value_token(32'h00010000));
      token_queue.push_back(oper_token(OP_END));
      token_queue.push_back(value_token(32'h00030000));
      token_queue.push_back(oper_token(OP_DIV));
      token_queue.push_back(value_token(32'h0));
      token_queue.push_back(oper_token(OP_END));          // divide by zero
      token_queue.push_back(oper_token(OP_CLOSE));        // close not after value
      token_queue.push_back(oper_token(OP_OPEN));
      token_queue.push_back(value_token(32'hFFFF8000));
      token_queue.push_back(oper_token(OP_END));          // end with open bracket
      token_queue.push_back(value_token(32'h1));
      token_queue.push_back(value_token(32'h2));          // operand after value
      token_queue.push_back(oper_token(OP_BAD));          // unused code
      token_queue.push_back(value_token(32'h1));
      token_queue.push_back(oper_token(OP_CLOSE));        // unmatched close
      token_queue.push_back(value_token(32'h5));
      token_queue.push_back(oper_token(OP_OPEN));         // open after value
      // operator stack overflow via open brackets
      for (int i = 0; i < 17; i++) token_queue.push_back(oper_token(OP_OPEN));
      // deep nesting, fills the operator stack again
      for (int i = 0; i < 16; i++) begin
         token_queue.push_back(value_token(i));
         token_queue.push_back(oper_token(OP_ADD));
         token_queue.push_back(oper_token(OP_OPEN));
      end
      token_queue.push_back(oper_token(OP_END));
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (token_queue.size() == 0);
      // sender pauses until every expected result has come
      hold_for_drain = 1;
      push_expression(0);
      wait (token_queue.size() == 0 && answer_queue.size() == 0);
      hold_for_drain = 0;
      count = 0;
      while (count < RANDOM_ITEMS) begin
         if (count > RANDOM_ITEMS - QUIET_TAIL) quiet = 1;
         before_n = token_queue.size();
         case ($urandom_range(0, 9))
            0: begin
               if ($urandom_range(0, 1)) token_queue.push_back(value_token(rand_value()));
               else token_queue.push_back(oper_token(3'($urandom_range(0, 7))));
            end
            1: push_expression(1);
            default: push_expression(0);
         endcase
         count += token_queue.size() - before_n;
         wait (token_queue.size() < 8);
      end
      stim_done = 1;
      wait (token_queue.size() == 0 && answer_queue.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && answer_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
